// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A trigger that must be followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`endif

// ===== rtl/core/pfe_pkg.sv =====
// Package with types and constants of the postfix expression evaluator.
package pfe_pkg;
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [31:0] DEC_BASE = 32'd10;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW
   } alu_op_type;

   typedef enum logic [1:0] {
      SEL_HOLD, SEL_UP, SEL_DOWN
   } cell_sel_type;

   typedef enum logic [1:0] {
      MODE_HOLD, MODE_PUSH, MODE_REPLACE
   } stack_mode_type;

   typedef enum logic [1:0] {
      S_IDLE, S_PROC, S_WAIT_ALU
   } top_state_type;

   typedef enum logic [2:0] {
      A_IDLE, A_DIV, A_DIV_FIN, A_POW, A_DONE
   } alu_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic divz;
   } alu_rsp_type;
endpackage

// ===== rtl/core/postfix_expression_evaluator_top.sv =====
// Top level of the postfix expression evaluator with its cell stack and sequencer.
// The req channel carries one ASCII character per item on req_char_code.
// Digits build a number; the first non-digit pushes it and is then processed.
// The characters + - * / % ^ pop two operands and push the result; a newline
// or NUL ends the expression and gives one rsp item with the top of the stack
// on rsp_answer and the first error on rsp_status, then the state clears.
// A digit item is taken in the idle state; any other character goes on to a
// processing state. An operator with two operands then waits for the ALU:
// add, subtract, multiply, a zero divisor or a negative exponent go straight
// to its done state; division and modulo use the one-bit-per-cycle divider and
// power the square-and-multiply loop. The stack is a row of STACK_DEPTH cells
// that shift one place on a push and on an operation.
// The result is registered from the S_PROC state of the ending item; an
// ending character waits only while an earlier result is still not taken.
// Reset empties the stack and clears the accumulator and the error status.
module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_answer,
   output logic [1:0]  rsp_status
);
   import pfe_pkg::*;
   `include "assert_macros.svh"

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   top_state_type  state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    acc_ff, acc_in;
   logic           innum_ff, innum_in;
   status_type     err_ff, err_in;
   logic [7:0]     char_ff, char_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    answer_ff, answer_in;
   logic [1:0]     status_ff, status_in;

   stack_mode_type mode;
   logic [31:0]    top_val;
   alu_req_type    alu_req;
   alu_rsp_type    alu_rsp;
   logic [31:0]    alu_result;
   logic [31:0]    cell_data [STACK_DEPTH];
   logic           is_digit;
   logic           is_end;
   logic           is_op;
   logic           out_free;
   alu_op_type     op_code;
   logic           end_fire;
   logic           state_clear;

   always_comb begin
      is_digit = (req_char_code >= CH_0) && (req_char_code <= CH_9);
      is_end   = (char_ff == CH_NL) || (char_ff == CH_NUL);
      is_op    = 1'b1;
      case (char_ff)
         CH_PLUS:  op_code = OP_ADD;
         CH_MINUS: op_code = OP_SUB;
         CH_STAR:  op_code = OP_MUL;
         CH_SLASH: op_code = OP_DIV;
         CH_PCT:   op_code = OP_MOD;
         CH_CARET: op_code = OP_POW;
         default: begin
            op_code = OP_ADD;
            is_op   = 1'b0;
         end
      endcase
      out_free = !rsp_valid_ff || rsp_ready;

      state_in     = state_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      innum_in     = innum_ff;
      err_in       = err_ff;
      char_in      = char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      answer_in    = answer_ff;
      status_in    = status_ff;
      mode         = MODE_HOLD;
      top_val      = acc_ff;
      alu_req      = '{start: 1'b0, op: op_code};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (is_digit) begin
                  acc_in   = 32'(acc_ff * DEC_BASE) + {24'd0, req_char_code - CH_0};
                  innum_in = 1'b1;
               end else begin
                  if (innum_ff) begin
                     if (count_ff < DEPTH_C) begin
                        mode     = MODE_PUSH;
                        count_in = count_ff + CW'(1);
                     end else if (err_ff == ST_OK) begin
                        err_in = ST_OVER;
                     end
                  end
                  acc_in   = 32'd0;
                  innum_in = 1'b0;
                  char_in  = req_char_code;
                  state_in = S_PROC;
               end
            end
         end
         S_PROC: begin
            if (is_end) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  answer_in    = (count_ff != '0) ? cell_data[0] : 32'd0;
                  if (err_ff != ST_OK) begin
                     status_in = err_ff;
                  end else if (count_ff == '0) begin
                     status_in = ST_UNDER;
                  end else begin
                     status_in = ST_OK;
                  end
                  count_in = '0;
                  err_in   = ST_OK;
                  state_in = S_IDLE;
               end
            end else if (is_op) begin
               if (count_ff < CW'(2)) begin
                  if (err_ff == ST_OK) begin
                     err_in = ST_UNDER;
                  end
                  state_in = S_IDLE;
               end else begin
                  alu_req.start = 1'b1;
                  state_in      = S_WAIT_ALU;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WAIT_ALU: begin
            if (alu_rsp.done) begin
               top_val  = alu_result;
               mode     = MODE_REPLACE;
               count_in = count_ff - CW'(1);
               if (alu_rsp.divz && (err_ff == ST_OK)) begin
                  err_in = ST_DIVZ;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         acc_ff       <= 32'd0;
         innum_ff     <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         innum_ff     <= innum_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      answer_ff <= answer_in;
      status_ff <= status_in;
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      cell_sel_type sel;
      logic [31:0]  up_data;
      logic [31:0]  down_data;

      if (i == 0) begin : g_first
         assign up_data = top_val;
      end else begin : g_rest
         assign up_data = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign down_data = 32'd0;
      end else begin : g_inner
         assign down_data = cell_data[i+1];
      end

      always_comb begin
         case (mode)
            MODE_PUSH:    sel = SEL_UP;
            MODE_REPLACE: sel = (i == 0) ? SEL_UP : SEL_DOWN;
            default:      sel = SEL_HOLD;
         endcase
      end

      pfe_cell u_cell (
         .clock     (clock),
         .sel       (sel),
         .up_data   (up_data),
         .down_data (down_data),
         .data      (cell_data[i])
      );
   end

   pfe_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .lhs    (cell_data[1]),
      .rhs    (cell_data[0]),
      .rsp    (alu_rsp),
      .result (alu_result)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = answer_ff;
   assign rsp_status = status_ff;

   assign end_fire    = (state_ff == S_PROC) && is_end && out_free;
   assign state_clear = (count_ff == '0) && rsp_valid_ff && (err_ff == ST_OK);

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C, "stack count beyond depth")
   `ASSERT_ALWAYS(a_alu_done, clock, reset, !alu_rsp.done || (state_ff == S_WAIT_ALU), "stray result")
   `ASSERT_NEXT(a_end_clears, clock, reset, end_fire, state_clear, "ending item left state")
endmodule

// ===== rtl/core/pfe_cell.sv =====
// One stack cell: holds an entry and takes it from a neighbor on a shift.
module pfe_cell (
   input  logic                  clock,
   input  pfe_pkg::cell_sel_type sel,
   input  logic [31:0]           up_data,
   input  logic [31:0]           down_data,
   output logic [31:0]           data
);
   import pfe_pkg::*;

   logic [31:0] data_ff;
   logic [31:0] data_in;

   always_comb begin
      case (sel)
         SEL_UP:   data_in = up_data;
         SEL_DOWN: data_in = down_data;
         default:  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

// ===== rtl/core/pfe_alu.sv =====
// Multi-cycle arithmetic unit: add, subtract, multiply, divide, modulo, power.
module pfe_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pfe_pkg::alu_req_type req,
   input  logic [31:0]          lhs,
   input  logic [31:0]          rhs,
   output pfe_pkg::alu_rsp_type rsp,
   output logic [31:0]          result
);
   import pfe_pkg::*;

   alu_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] res_ff, res_in;
   logic        divz_ff, divz_in;
   logic        negq_ff, negq_in;
   logic        negr_ff, negr_in;
   logic        mod_ff, mod_in;

   logic [32:0] shifted;
   logic [32:0] diff;
   logic [31:0] mag_l;
   logic [31:0] mag_r;
   logic [31:0] prod_r;
   logic [31:0] prod_b;

   always_comb begin
      mag_l   = lhs[31] ? 32'(-lhs) : lhs;
      mag_r   = rhs[31] ? 32'(-rhs) : rhs;
      shifted = {r_ff, a_ff[31]};
      diff    = shifted - {1'b0, b_ff};
      prod_r  = 32'(r_ff * a_ff);
      prod_b  = 32'(a_ff * a_ff);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      res_in   = res_ff;
      divz_in  = divz_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      mod_in   = mod_ff;

      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               divz_in  = 1'b0;
               state_in = A_DONE;
               case (req.op)
                  OP_ADD: res_in = lhs + rhs;
                  OP_SUB: res_in = lhs - rhs;
                  OP_MUL: res_in = 32'(lhs * rhs);
                  OP_DIV, OP_MOD: begin
                     if (rhs == 32'd0) begin
                        res_in  = 32'd0;
                        divz_in = 1'b1;
                     end else begin
                        a_in     = mag_l;
                        b_in     = mag_r;
                        r_in     = 32'd0;
                        cnt_in   = 5'd0;
                        negq_in  = lhs[31] ^ rhs[31];
                        negr_in  = lhs[31];
                        mod_in   = (req.op == OP_MOD);
                        state_in = A_DIV;
                     end
                  end
                  default: begin
                     if (rhs[31]) begin
                        if (lhs == 32'd1) begin
                           res_in = 32'd1;
                        end else if (lhs == 32'hFFFF_FFFF) begin
                           res_in = rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                        end else begin
                           res_in  = 32'd0;
                           divz_in = (lhs == 32'd0);
                        end
                     end else begin
                        a_in     = lhs;
                        b_in     = rhs;
                        r_in     = 32'd1;
                        cnt_in   = 5'd0;
                        state_in = A_POW;
                     end
                  end
               endcase
            end
         end
         A_DIV: begin
            if (!diff[32]) begin
               r_in = diff[31:0];
            end else begin
               r_in = shifted[31:0];
            end
            a_in   = {a_ff[30:0], !diff[32]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = A_DIV_FIN;
            end
         end
         A_DIV_FIN: begin
            if (mod_ff) begin
               res_in = negr_ff ? 32'(-r_ff) : r_ff;
            end else begin
               res_in = negq_ff ? 32'(-a_ff) : a_ff;
            end
            state_in = A_DONE;
         end
         A_POW: begin
            if (b_ff[cnt_ff]) begin
               r_in = prod_r;
            end
            a_in   = prod_b;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) begin
               res_in   = b_ff[cnt_ff] ? prod_r : r_ff;
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      res_ff  <= res_in;
      divz_ff <= divz_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      mod_ff  <= mod_in;
   end

   assign rsp.done = (state_ff == A_DONE);
   assign rsp.divz = divz_ff;
   assign result   = res_ff;
endmodule
